### rtl/bqeh_pkg.sv
// Shared types, constants and helpers for the base quality error histogram.
package bqeh_pkg;

	localparam int MAX_READ_LENGTH = 128;
	localparam int QUALITY_LEVELS  = 60;
	localparam int COUNTER_WIDTH   = 32;

	localparam int CONTEXTS     = 20;
	localparam int CYCLES       = 2 * MAX_READ_LENGTH;
	localparam int ROW_SIZE     = CONTEXTS * CYCLES;
	localparam int DEPTH        = QUALITY_LEVELS * ROW_SIZE;
	localparam int PRESET_SCORE = 2;
	localparam int PRESET_TOTAL = 10000;
	localparam int PRESET_ERROR = 6310;
	localparam int QUEUE_DEPTH  = 2;

	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int SCORE_W = $clog2(QUALITY_LEVELS);
	localparam int CTX_W   = $clog2(CONTEXTS);
	localparam int CYC_W   = $clog2(CYCLES);
	localparam int LEN_W   = $clog2(MAX_READ_LENGTH + 1);
	localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

	localparam int RESET_READ_LENGTH    = 125;
	localparam int RESET_QUALITY_OFFSET = 33;

	// operation codes
	localparam logic OP_ACCUM = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_BAD_BASE  = 2'd1;
	localparam logic [1:0] ST_BAD_QUAL  = 2'd2;
	localparam logic [1:0] ST_BAD_CYCLE = 2'd3;

	// register indexes
	localparam logic CFG_READ_LENGTH    = 1'b0;
	localparam logic CFG_QUALITY_OFFSET = 1'b1;

	localparam logic [1:0] BASE_COMP [4] = '{2'd3, 2'd2, 2'd1, 2'd0};

	typedef logic [COUNTER_WIDTH-1:0] cnt_t;
	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		logic       operation;
		logic [2:0] read_base;
		logic [2:0] neighbour_base;
		logic [7:0] quality_char;
		logic [6:0] position_in_read;
		logic       reverse_strand;
		logic       second_mate;
		logic [2:0] ref_base;
		logic [2:0] alt_base;
		logic [7:0] readout_cycle;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] all_count;
		logic [31:0] error_count;
	} result_t;

	typedef struct packed {
		logic [1:0] status;
		logic       accum;
		logic       has_nb;
		logic       is_err;
		addr_t      idx_addr;
		addr_t      plain_addr;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic addr_t slot(logic [SCORE_W-1:0] score, logic [CTX_W-1:0] ctx,
			logic [CYC_W-1:0] cycle);
		logic [31:0] s;
		s = 32'(score) * 32'(ROW_SIZE) + 32'(ctx) * 32'(CYCLES) + 32'(cycle);
		return s[ADDR_W-1:0];
	endfunction

	function automatic cnt_t sat_inc(cnt_t v);
		return (v == '1) ? v : v + cnt_t'(1);
	endfunction

	function automatic logic [31:0] clip_out(cnt_t v);
		logic [63:0] ext;
		ext = 64'(v);
		return (ext > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : ext[31:0];
	endfunction

endpackage

### rtl/base_quality_error_histogram.sv
// Sequence: a flagged command goes from the queue straight to the done strobe, a counter read or
// single update passes through S_IDX, and an update with neighbour context through S_IDX and S_PLN.
// The back end holds one command at a time and takes no new one from the queue until it is through
// with the last, as the counter memories have a single read port and a single write port.
// Reset: busy stays high for a clearing pass over all 307200 counter pairs, one counter pair a cycle;
// config writes are taken throughout. done cannot be held off by the receiver.
module base_quality_error_histogram import bqeh_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  cmd_t       cmd,
	output logic       done,
	output result_t    result,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);

	logic      clearing;
	q_status_t qstat;
	logic      push;
	q_entry_t  push_entry;
	logic      pop;
	q_entry_t  head;

	bqeh_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.cmd        (cmd),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.clearing   (clearing),
		.qstat      (qstat),
		.push       (push),
		.push_entry (push_entry)
	);

	bqeh_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.qstat      (qstat)
	);

	bqeh_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.qstat    (qstat),
		.head     (head),
		.pop      (pop),
		.clearing (clearing),
		.done     (done),
		.result   (result)
	);

endmodule

### rtl/bqeh_front.sv
// Front end: command accept, config registers, classification and address generation.
module bqeh_front import bqeh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  cmd_t      cmd,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic      cfg_index,
	input  logic [7:0] cfg_data,
	input  logic      clearing,
	input  q_status_t qstat,
	output logic      push,
	output q_entry_t  push_entry
);

	logic [7:0] read_length_q;
	logic [6:0] quality_offset_q;

	logic [LEN_W-1:0]   len;
	logic [8:0]         qdiff;
	logic               qual_bad;
	logic               cyc_bad;
	logic [SCORE_W-1:0] score;
	logic [1:0]         b;
	logic [1:0]         n;
	logic [LEN_W-1:0]   c;
	logic [CYC_W-1:0]   cycle;
	logic               has_nb;
	logic [CTX_W-1:0]   ctx_acc;
	logic [CTX_W-1:0]   ctx_rd;

	assign cfg_ready = 1'b1;
	assign busy      = clearing | qstat.full;
	assign push      = start & ~busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_length_q    <= 8'(RESET_READ_LENGTH);
			quality_offset_q <= 7'(RESET_QUALITY_OFFSET);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_READ_LENGTH:    read_length_q    <= cfg_data;
				CFG_QUALITY_OFFSET: quality_offset_q <= cfg_data[6:0];
			endcase
		end
	end

	always_comb begin
		if (read_length_q == 8'd0)
			len = LEN_W'(1);
		else if (16'(read_length_q) > 16'(MAX_READ_LENGTH))
			len = LEN_W'(MAX_READ_LENGTH);
		else
			len = LEN_W'(read_length_q);

		qdiff    = {1'b0, cmd.quality_char} - {2'b00, quality_offset_q};
		qual_bad = (cmd.quality_char < {1'b0, quality_offset_q}) ||
			(qdiff >= 9'(QUALITY_LEVELS));
		score    = SCORE_W'(qdiff);

		if (cmd.operation == OP_READ)
			cyc_bad = 16'(cmd.readout_cycle) >= (16'(len) + 16'(len));
		else
			cyc_bad = 16'(cmd.position_in_read) >= 16'(len);

		// reverse strand: complement bases, mirror cycle within the mate
		b = cmd.reverse_strand ? BASE_COMP[cmd.read_base[1:0]] : cmd.read_base[1:0];
		n = cmd.reverse_strand ? BASE_COMP[cmd.neighbour_base[1:0]]
			: cmd.neighbour_base[1:0];
		c = cmd.reverse_strand ? len - LEN_W'(1) - LEN_W'(cmd.position_in_read)
			: LEN_W'(cmd.position_in_read);
		cycle  = CYC_W'(c) + (cmd.second_mate ? CYC_W'(len) : CYC_W'(0));
		has_nb = (c != '0) && (cmd.neighbour_base <= 3'd3);

		ctx_acc = has_nb ? CTX_W'({1'b0, n, b}) + CTX_W'(4) : CTX_W'(b);
		ctx_rd  = (cmd.neighbour_base <= 3'd3)
			? CTX_W'({1'b0, cmd.neighbour_base[1:0], cmd.read_base[1:0]}) + CTX_W'(4)
			: CTX_W'(cmd.read_base[1:0]);

		push_entry = '0;
		if (cmd.read_base > 3'd3)
			push_entry.status = ST_BAD_BASE;
		else if (qual_bad)
			push_entry.status = ST_BAD_QUAL;
		else if (cyc_bad)
			push_entry.status = ST_BAD_CYCLE;
		else
			push_entry.status = ST_OK;

		if (cmd.operation == OP_READ) begin
			push_entry.idx_addr   = slot(score, ctx_rd, CYC_W'(cmd.readout_cycle));
			push_entry.plain_addr = push_entry.idx_addr;
		end else begin
			push_entry.accum      = 1'b1;
			push_entry.has_nb     = has_nb;
			push_entry.is_err     = (cmd.read_base != cmd.ref_base) &&
				(cmd.read_base != cmd.alt_base);
			push_entry.idx_addr   = slot(score, ctx_acc, cycle);
			push_entry.plain_addr = slot(score, CTX_W'(b), cycle);
		end
	end

endmodule

### rtl/bqeh_fifo.sv
// Short queue of classified commands between front and back end.
module bqeh_fifo import bqeh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  q_entry_t  push_entry,
	input  logic      pop,
	output q_entry_t  head,
	output q_status_t qstat
);

	q_entry_t          mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	assign head        = mem_q[rd_ptr_q];
	assign qstat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign qstat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

endmodule

### rtl/bqeh_back.sv
// Back end: counter tables, clearing pass, read-modify-write sequencer and result register.
module bqeh_back import bqeh_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  q_status_t qstat,
	input  q_entry_t  head,
	output logic      pop,
	output logic      clearing,
	output logic      done,
	output result_t   result
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_IDX  = 2'd1;
	localparam logic [1:0] S_PLN  = 2'd2;

	cnt_t tot_mem [DEPTH];
	cnt_t err_mem [DEPTH];

	logic [1:0] state_q;
	q_entry_t   cur_q;
	cnt_t       rd_tot_q;
	cnt_t       rd_err_q;
	logic       clr_active_q;
	addr_t      clr_addr_q;
	logic       done_q;
	result_t    result_q;

	logic  rd_en;
	addr_t rd_addr;
	logic  wr_en;
	addr_t wr_addr;
	cnt_t  wr_tot;
	cnt_t  wr_err;
	cnt_t  new_tot;
	cnt_t  new_err;
	logic  clr_preset;

	assign clearing = clr_active_q;
	assign done     = done_q;
	assign result   = result_q;
	assign pop      = (state_q == S_IDLE) && !clr_active_q && !qstat.empty;

	assign new_tot = sat_inc(rd_tot_q);
	assign new_err = cur_q.is_err ? sat_inc(rd_err_q) : rd_err_q;

	assign clr_preset = (clr_addr_q >= ADDR_W'(PRESET_SCORE * ROW_SIZE)) &&
		(clr_addr_q < ADDR_W'((PRESET_SCORE + 1) * ROW_SIZE));

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = head.idx_addr;
		if (pop && head.status == ST_OK) begin
			rd_en = 1'b1;
		end else if (state_q == S_IDX && cur_q.accum && cur_q.has_nb) begin
			rd_en   = 1'b1;
			rd_addr = cur_q.plain_addr;
		end
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = cur_q.idx_addr;
		wr_tot  = new_tot;
		wr_err  = new_err;
		if (clr_active_q) begin
			wr_en   = 1'b1;
			wr_addr = clr_addr_q;
			wr_tot  = clr_preset ? cnt_t'(PRESET_TOTAL) : '0;
			wr_err  = clr_preset ? cnt_t'(PRESET_ERROR) : '0;
		end else if (state_q == S_IDX && cur_q.accum) begin
			wr_en = 1'b1;
		end else if (state_q == S_PLN) begin
			wr_en   = 1'b1;
			wr_addr = cur_q.plain_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			tot_mem[wr_addr] <= wr_tot;
			err_mem[wr_addr] <= wr_err;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_tot_q <= tot_mem[rd_addr];
			rd_err_q <= err_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head;
		if (pop && head.status != ST_OK) begin
			result_q <= {head.status, 32'd0, 32'd0};
		end else if (state_q == S_IDX) begin
			result_q.status      <= ST_OK;
			result_q.all_count   <= clip_out(cur_q.accum ? new_tot : rd_tot_q);
			result_q.error_count <= clip_out(new_err);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			clr_active_q <= 1'b1;
			clr_addr_q   <= '0;
			done_q       <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (clr_active_q) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
				if (clr_addr_q == ADDR_W'(DEPTH - 1))
					clr_active_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (head.status == ST_OK)
							state_q <= S_IDX;
						else
							done_q <= 1'b1;
					end
				end
				S_IDX: begin
					if (cur_q.accum && cur_q.has_nb) begin
						state_q <= S_PLN;
					end else begin
						state_q <= S_IDLE;
						done_q  <= 1'b1;
					end
				end
				S_PLN: begin
					state_q <= S_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_no_work_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_active_q |-> (!pop && !done_q && state_q == S_IDLE))
		else $error("command processed during clearing pass");

	a_plain_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_PLN |-> (cur_q.accum && cur_q.has_nb &&
			cur_q.plain_addr != cur_q.idx_addr))
		else $error("second update without a distinct context-free address");

	a_flagged_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && result_q.status != ST_OK) |->
			(result_q.all_count == 32'd0 && result_q.error_count == 32'd0))
		else $error("flagged result carries counts");

	a_idx_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDX && !(cur_q.accum && cur_q.has_nb)) |=> done_q)
		else $error("single-update command did not deliver a result");

endmodule

### test/base_quality_error_histogram_checker.sv
`timescale 1ns / 1ps
// Result checker: models the two counter tables and compares every done beat in order.
module base_quality_error_histogram_checker import bqeh_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  cmd_t        cmd,
	input  logic        done,
	input  result_t     result,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data,
	output int unsigned mismatch_count,
	output int unsigned pending_count
);

	// sparse copy of the tables: untouched cells read as their reset value
	cnt_t total_hist [int];
	cnt_t error_hist [int];
	logic [7:0] read_length_q;
	logic [6:0] quality_offset_q;
	result_t expected_q [$];

	assign pending_count = expected_q.size();

	function automatic int cell_index(int score, int ctx, int cyc);
		return (score * CONTEXTS + ctx) * CYCLES + cyc;
	endfunction

	function automatic cnt_t total_at(int i);
		if (total_hist.exists(i))
			return total_hist[i];
		return (i / ROW_SIZE == PRESET_SCORE) ? cnt_t'(PRESET_TOTAL) : '0;
	endfunction

	function automatic cnt_t error_at(int i);
		if (error_hist.exists(i))
			return error_hist[i];
		return (i / ROW_SIZE == PRESET_SCORE) ? cnt_t'(PRESET_ERROR) : '0;
	endfunction

	function automatic void bump_cell(bit err_side, int i);
		cnt_t v;
		v = err_side ? error_at(i) : total_at(i);
		if (v != '1) begin
			if (err_side)
				error_hist[i] = v + cnt_t'(1);
			else
				total_hist[i] = v + cnt_t'(1);
		end
	endfunction

	function automatic result_t histogram_step(cmd_t c);
		result_t res;
		int len, qc, off, score, base, nb, b, n, pos, cyc, idx, plain;
		bit has_nb, is_err;
		res = '0;
		len = (read_length_q == 0) ? 1 :
			(read_length_q > MAX_READ_LENGTH) ? MAX_READ_LENGTH : int'(read_length_q);
		qc = c.quality_char;
		off = quality_offset_q;
		base = c.read_base;
		nb = c.neighbour_base;
		if (base > 3)
			res.status = ST_BAD_BASE;
		else if (qc < off || qc - off >= QUALITY_LEVELS)
			res.status = ST_BAD_QUAL;
		else if (c.operation == OP_ACCUM ? int'(c.position_in_read) >= len
				: int'(c.readout_cycle) >= 2 * len)
			res.status = ST_BAD_CYCLE;
		if (res.status != ST_OK)
			return res;
		score = qc - off;
		if (c.operation == OP_READ) begin
			idx = cell_index(score, (nb <= 3) ? 4 + 4 * nb + base : base, c.readout_cycle);
		end else begin
			pos = c.position_in_read;
			b = c.reverse_strand ? 3 - base : base;
			cyc = c.reverse_strand ? len - 1 - pos : pos;
			// first cycle of a mate has no preceding base
			has_nb = (cyc != 0) && (nb <= 3);
			n = c.reverse_strand ? 3 - nb : nb;
			if (c.second_mate)
				cyc += len;
			idx = cell_index(score, has_nb ? 4 + 4 * n + b : b, cyc);
			plain = cell_index(score, b, cyc);
			is_err = (base != int'(c.ref_base)) && (base != int'(c.alt_base));
			bump_cell(1'b0, idx);
			if (has_nb)
				bump_cell(1'b0, plain);
			if (is_err) begin
				bump_cell(1'b1, idx);
				if (has_nb)
					bump_cell(1'b1, plain);
			end
		end
		res.all_count = total_at(idx);
		res.error_count = error_at(idx);
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			total_hist.delete();
			error_hist.delete();
			expected_q.delete();
			read_length_q = 8'(RESET_READ_LENGTH);
			quality_offset_q = 7'(RESET_QUALITY_OFFSET);
			mismatch_count = 0;
		end else begin
			if (done) begin
				if (expected_q.size() == 0) begin
					if (mismatch_count < 10)
						$display("%t: result beat with nothing outstanding: status %0d all %0d err %0d",
							$realtime, result.status, result.all_count, result.error_count);
					mismatch_count++;
				end else begin
					want = expected_q.pop_front();
					if (result.status !== want.status || result.all_count !== want.all_count ||
							result.error_count !== want.error_count) begin
						if (mismatch_count < 10)
							$display("%t: mismatch: want status %0d all %0d err %0d, got %0d %0d %0d",
								$realtime, want.status, want.all_count, want.error_count,
								result.status, result.all_count, result.error_count);
						mismatch_count++;
					end
				end
			end
			if (start && !busy)
				expected_q.insert(expected_q.size(), histogram_step(cmd));
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_READ_LENGTH)
					read_length_q = cfg_data;
				else
					quality_offset_q = cfg_data[6:0];
			end
		end
	end

endmodule

### test/base_quality_error_histogram_test.sv
`timescale 1ns / 1ps
// Testbench top: drives commands and register writes, runs the checker, gives the verdict.
module base_quality_error_histogram_test;
	import bqeh_pkg::*;

	// reset clearing pass alone is quiet while it writes all 307200 counter pairs
	localparam int WATCHDOG_LIMIT = 1200000;
	localparam int PHASES = 6;
	localparam int ITEMS_PER_PHASE = 272;

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	cmd_t        cmd;
	logic        done;
	result_t     result;
	logic        cfg_valid;
	logic        cfg_ready;
	logic        cfg_index;
	logic [7:0]  cfg_data;
	int unsigned mismatch_count;
	int unsigned pending_count;
	int unsigned quiet_cycles;
	cmd_t        items [$];

	int phase_len  [PHASES] = '{125, 1, 128, 0, 255, 37};
	int phase_off  [PHASES] = '{33, 0, 64, 127, 20, 33};
	int phase_idle [PHASES] = '{0, 51, 28, 0, 51, 28};

	base_quality_error_histogram u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.cmd       (cmd),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	base_quality_error_histogram_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.cmd            (cmd),
		.done           (done),
		.result         (result),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((start && !busy) || done || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("base_quality_error_histogram_test: errors");
				$finish;
			end
		end
	end

	function automatic void queue_item(cmd_t c);
		items.insert(items.size(), c);
	endfunction

	function automatic cmd_t base_cmd(logic op, int base, int nb, int qc, int pos, bit rev,
			bit mate, int refb, int altb, int rcyc);
		cmd_t c;
		c.operation = op;
		c.read_base = 3'(base);
		c.neighbour_base = 3'(nb);
		c.quality_char = 8'(qc);
		c.position_in_read = 7'(pos);
		c.reverse_strand = rev;
		c.second_mate = mate;
		c.ref_base = 3'(refb);
		c.alt_base = 3'(altb);
		c.readout_cycle = 8'(rcyc);
		return c;
	endfunction

	// mostly well-formed beats on a small set of cells so counters pile up
	function automatic cmd_t random_cmd(int len, int off);
		cmd_t c;
		logic [63:0] raw;
		int score, r;
		raw = {$urandom, $urandom};
		c = raw[$bits(cmd_t)-1:0];
		r = $urandom_range(99);
		if (r < 15)
			return c;
		c.read_base = 3'($urandom_range(3));
		case ($urandom_range(9))
			0: score = 0;
			1: score = QUALITY_LEVELS - 1;
			2: score = -1;
			3: score = QUALITY_LEVELS;
			default: score = $urandom_range(4);
		endcase
		c.quality_char = 8'(off + score);
		c.neighbour_base = 3'($urandom_range(7));
		c.ref_base = $urandom_range(1) ? c.read_base : 3'($urandom_range(7));
		c.alt_base = 3'($urandom_range(7));
		if (r < 60) begin
			c.operation = OP_ACCUM;
			case ($urandom_range(7))
				0: c.position_in_read = 7'(len - 1);
				1: c.position_in_read = (len < MAX_READ_LENGTH) ? 7'(len) : 7'(len - 1);
				2: c.position_in_read = 7'($urandom_range(len - 1));
				default: c.position_in_read = 7'($urandom_range((len < 4) ? len - 1 : 3));
			endcase
		end else begin
			c.operation = OP_READ;
			case ($urandom_range(7))
				0: c.readout_cycle = 8'(len - 1);
				1: c.readout_cycle = 8'(len + $urandom_range(1));
				2: c.readout_cycle = 8'(2 * len - 1);
				3: c.readout_cycle = 8'(2 * len);
				4: c.readout_cycle = 8'($urandom_range(2 * len - 1));
				default: c.readout_cycle = 8'($urandom_range((len < 2) ? 1 : 3));
			endcase
		end
		return c;
	endfunction

	// both registers in one burst so valid never drops between the two beats
	task automatic program_regs(input logic [7:0] len, input logic [7:0] off);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_READ_LENGTH;
		cfg_data <= len;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= CFG_QUALITY_OFFSET;
		cfg_data <= off;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic issue(input cmd_t c);
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
	endtask

	task automatic drain();
		while (pending_count != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	initial begin
		int len, gap;
		arst_n = 1'b0;
		start = 1'b0;
		cmd = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_READ_LENGTH;
		cfg_data = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int p = 0; p < PHASES; p++) begin
			if (p > 0)
				drain();
			program_regs(8'(phase_len[p]), 8'(phase_off[p]));
			len = (phase_len[p] == 0) ? 1 :
				(phase_len[p] > MAX_READ_LENGTH) ? MAX_READ_LENGTH : phase_len[p];
			items.delete();
			if (p == 0) begin
				// preset quality-2 rows, last valid read cycle and one past it
				queue_item(base_cmd(OP_READ, 0, 4, 35, 0, 0, 0, 0, 0, 0));
				queue_item(base_cmd(OP_READ, 3, 3, 35, 0, 0, 0, 0, 0, 249));
				queue_item(base_cmd(OP_READ, 3, 3, 35, 0, 0, 0, 0, 0, 250));
				// cycle zero drops the neighbour; ref match, alt match, then errors
				queue_item(base_cmd(OP_ACCUM, 1, 2, 33, 0, 0, 0, 1, 4, 0));
				queue_item(base_cmd(OP_ACCUM, 1, 2, 33, 0, 0, 0, 2, 1, 0));
				queue_item(base_cmd(OP_ACCUM, 1, 2, 33, 0, 0, 0, 2, 3, 0));
				queue_item(base_cmd(OP_ACCUM, 1, 2, 33, 0, 0, 0, 2, 3, 0));
				queue_item(base_cmd(OP_ACCUM, 1, 2, 33, 0, 0, 0, 2, 3, 0));
				// neighbour context also bumps the context-free cell
				queue_item(base_cmd(OP_ACCUM, 2, 0, 33, 5, 0, 0, 4, 7, 0));
				queue_item(base_cmd(OP_READ, 2, 4, 33, 0, 0, 0, 0, 0, 5));
				queue_item(base_cmd(OP_READ, 2, 7, 33, 0, 0, 0, 0, 0, 5));
				// reverse strand, second mate, top score
				queue_item(base_cmd(OP_ACCUM, 0, 1, 92, 124, 1, 1, 0, 0, 0));
				queue_item(base_cmd(OP_ACCUM, 2, 3, 92, 0, 1, 1, 2, 4, 0));
				queue_item(base_cmd(OP_READ, 1, 0, 92, 0, 0, 0, 0, 0, 249));
				queue_item(base_cmd(OP_ACCUM, 0, 4, 33, 125, 0, 0, 0, 0, 0));
				queue_item(base_cmd(OP_ACCUM, 0, 4, 33, 127, 0, 0, 0, 0, 0));
				queue_item(base_cmd(OP_ACCUM, 0, 4, 32, 0, 0, 0, 0, 0, 0));
				queue_item(base_cmd(OP_ACCUM, 0, 4, 93, 0, 0, 0, 0, 0, 0));
				// priority: bad base over quality and cycle, quality over cycle
				queue_item(base_cmd(OP_ACCUM, 4, 4, 255, 127, 0, 0, 0, 0, 0));
				queue_item(base_cmd(OP_ACCUM, 3, 4, 0, 127, 0, 0, 0, 0, 0));
				queue_item(base_cmd(OP_READ, 5, 0, 33, 0, 0, 0, 0, 0, 0));
				queue_item(base_cmd(OP_ACCUM, 0, 1, 35, 3, 0, 0, 4, 4, 0));
				queue_item(base_cmd(OP_ACCUM, 0, 0, 0, 0, 0, 0, 0, 0, 0));
				queue_item(cmd_t'('1));
			end
			repeat (ITEMS_PER_PHASE)
				queue_item(random_cmd(len, phase_off[p]));
			foreach (items[i]) begin
				if (i > 0) begin
					gap = 0;
					while ($urandom_range(99) < phase_idle[p])
						gap++;
					if (gap > 0) begin
						start <= 1'b0;
						repeat (gap) @(posedge clk);
					end
				end
				issue(items[i]);
			end
			start <= 1'b0;
		end
		drain();
		if (mismatch_count == 0 && pending_count == 0)
			$display("base_quality_error_histogram_test: clean");
		else
			$display("base_quality_error_histogram_test: errors");
		$finish;
	end

endmodule

### files.f
rtl/bqeh_pkg.sv
rtl/bqeh_front.sv
rtl/bqeh_fifo.sv
rtl/bqeh_back.sv
rtl/base_quality_error_histogram.sv
test/base_quality_error_histogram_checker.sv
test/base_quality_error_histogram_test.sv
